FILE: rtl/prq_pkg.sv
// Package for the priority run queue insert/remove unit.
// Holds the default sizes, the command and status codes, and the transaction structs.
// No dependencies.
package prq_pkg;

    localparam int PRQ_NUM_THREADS = 64;
    localparam int PRQ_NUM_QUEUES  = 32;
    localparam int PRQ_PRIO_SHIFT  = 2;

    localparam int PRQ_TID_W    = 6;
    localparam int PRQ_PRIO_W   = 7;
    localparam int PRQ_BITMAP_W = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } prq_cmd_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_DUP_INSERT = 2'd1,
        ST_BAD_REMOVE = 2'd2
    } prq_status_t;

    typedef struct packed {
        prq_cmd_t                cmd;
        logic [PRQ_TID_W-1:0]    thread_id;
        logic [PRQ_PRIO_W-1:0]   priority_req;
    } prq_op_t;

    typedef struct packed {
        prq_status_t               status;
        logic [PRQ_BITMAP_W-1:0]   bitmap;
    } prq_res_t;

endpackage

FILE: rtl/prq_queue_core.sv
// Run queue state: per-thread link tables, queued flags, queue head/tail anchors, bitmap.
// Applies one insert or remove per enabled cycle and returns status and the updated bitmap.
// Depends on prq_pkg.
module prq_queue_core
    import prq_pkg::*;
#(
    parameter int NUM_THREADS = PRQ_NUM_THREADS,
    parameter int NUM_QUEUES  = PRQ_NUM_QUEUES,
    parameter int PRIO_SHIFT  = PRQ_PRIO_SHIFT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic [PRQ_TID_W-1:0] load_tid,
    input  logic                 fire,
    input  prq_op_t              op,
    output prq_res_t             res
);

    localparam int NODE_COUNT = NUM_THREADS + NUM_QUEUES;
    localparam int TW = $clog2(NUM_THREADS);
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int BW = (NUM_QUEUES > PRQ_BITMAP_W) ? NUM_QUEUES : PRQ_BITMAP_W;

    logic [NW-1:0]         next_link_reg [NUM_THREADS];
    logic [NW-1:0]         prev_link_reg [NUM_THREADS];
    logic [NUM_THREADS-1:0] queued_reg;
    logic [NW-1:0]         head_reg [NUM_QUEUES];
    logic [NW-1:0]         tail_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] bitmap_reg;
    logic [NUM_QUEUES-1:0] bitmap_next;

    logic [TW-1:0]         tmod [64];
    logic [TW-1:0]         t_idx;
    logic [NW-1:0]         t_node;
    logic [PRQ_PRIO_W-1:0] q_raw;
    logic [QW-1:0]         q_idx;
    logic [NW-1:0]         anc_q;
    logic [NUM_QUEUES-1:0] bit_q;
    logic                  is_ins;
    logic                  ins_ok;
    logic                  rem_ok;

    logic [NW-1:0] last;
    logic [NW-1:0] nx;
    logic [NW-1:0] pv;
    logic [NW-1:0] head_after;
    logic          last_thr, last_anc, nx_thr, nx_anc, pv_thr, pv_anc;

    logic [TW-1:0] ld_idx;
    logic [NW-1:0] nx_rd_reg;
    logic [NW-1:0] pv_rd_reg;
    logic          nx_hit;
    logic          pv_hit;
    logic [NW-1:0] nx_fwd;
    logic [NW-1:0] pv_fwd;

    logic [BW-1:0] bitmap_ext;

    genvar g;
    generate
        for (g = 0; g < 64; g++) begin : g_tmod
            assign tmod[g] = TW'(g % NUM_THREADS);
        end
    endgenerate

    function automatic logic node_is_thread(input logic [NW-1:0] node);
        return node < NW'(NUM_THREADS);
    endfunction

    function automatic logic node_is_anchor(input logic [NW-1:0] node);
        return (node >= NW'(NUM_THREADS)) && ({1'b0, node} < (NW+1)'(NODE_COUNT));
    endfunction

    function automatic logic [QW-1:0] node_queue(input logic [NW-1:0] node);
        logic [NW-1:0] d;
        d = node - NW'(NUM_THREADS);
        return d[QW-1:0];
    endfunction

    always_comb begin
        t_idx  = tmod[op.thread_id];
        t_node = NW'(t_idx);
        q_raw  = op.priority_req >> PRIO_SHIFT;
        if ({1'b0, q_raw} >= 8'(NUM_QUEUES)) begin
            q_idx = QW'(NUM_QUEUES - 1);
        end else begin
            q_idx = q_raw[QW-1:0];
        end
        anc_q = NW'(NUM_THREADS) + NW'(q_idx);
        bit_q = NUM_QUEUES'(1) << q_idx;
        is_ins = (op.cmd == CMD_INSERT);
        ins_ok = is_ins && !queued_reg[t_idx];
        rem_ok = !is_ins && queued_reg[t_idx] && ((bitmap_reg & bit_q) != '0);

        last = tail_reg[q_idx];
        nx   = nx_rd_reg;
        pv   = pv_rd_reg;
        last_thr = node_is_thread(last);
        last_anc = node_is_anchor(last);
        nx_thr   = node_is_thread(nx);
        nx_anc   = node_is_anchor(nx);
        pv_thr   = node_is_thread(pv);
        pv_anc   = node_is_anchor(pv);
        head_after = (pv == anc_q) ? nx : head_reg[q_idx];

        bitmap_next = bitmap_reg;
        if (ins_ok) begin
            bitmap_next = bitmap_reg | bit_q;
        end else if (rem_ok && (head_after == anc_q)) begin
            bitmap_next = bitmap_reg & ~bit_q;
        end

        if (is_ins) begin
            res.status = ins_ok ? ST_DONE : ST_DUP_INSERT;
        end else begin
            res.status = rem_ok ? ST_DONE : ST_BAD_REMOVE;
        end
        bitmap_ext = BW'(bitmap_next);
        res.bitmap = bitmap_ext[PRQ_BITMAP_W-1:0];

        // bypass of the link writes made on the same edge as the read
        ld_idx = tmod[load_tid];
        if (fire && ins_ok && (t_idx == ld_idx)) begin
            nx_hit = 1'b1;
            nx_fwd = anc_q;
        end else if (fire && ins_ok && last_thr && (last[TW-1:0] == ld_idx)) begin
            nx_hit = 1'b1;
            nx_fwd = t_node;
        end else if (fire && rem_ok && pv_thr && (pv[TW-1:0] == ld_idx)) begin
            nx_hit = 1'b1;
            nx_fwd = nx;
        end else begin
            nx_hit = 1'b0;
            nx_fwd = '0;
        end
        if (fire && ins_ok && (t_idx == ld_idx)) begin
            pv_hit = 1'b1;
            pv_fwd = last;
        end else if (fire && rem_ok && nx_thr && (nx[TW-1:0] == ld_idx)) begin
            pv_hit = 1'b1;
            pv_fwd = pv;
        end else begin
            pv_hit = 1'b0;
            pv_fwd = '0;
        end
    end

    // link tables: no reset, only used for queued threads; read when the transaction is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            nx_rd_reg <= nx_hit ? nx_fwd : next_link_reg[ld_idx];
            pv_rd_reg <= pv_hit ? pv_fwd : prev_link_reg[ld_idx];
        end
        if (fire && ins_ok) begin
            next_link_reg[t_idx] <= anc_q;
            prev_link_reg[t_idx] <= last;
            if (last_thr) begin
                next_link_reg[last[TW-1:0]] <= t_node;
            end
        end else if (fire && rem_ok) begin
            if (nx_thr) begin
                prev_link_reg[nx[TW-1:0]] <= pv;
            end
            if (pv_thr) begin
                next_link_reg[pv[TW-1:0]] <= nx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
            bitmap_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= NW'(NUM_THREADS + i);
                tail_reg[i] <= NW'(NUM_THREADS + i);
            end
        end else if (fire) begin
            bitmap_reg <= bitmap_next;
            if (ins_ok) begin
                queued_reg[t_idx] <= 1'b1;
                tail_reg[q_idx]   <= t_node;
                if (last_anc) begin
                    head_reg[node_queue(last)] <= t_node;
                end
            end else if (rem_ok) begin
                queued_reg[t_idx] <= 1'b0;
                if (nx_anc) begin
                    tail_reg[node_queue(nx)] <= pv;
                end
                if (pv_anc) begin
                    head_reg[node_queue(pv)] <= nx;
                end
            end
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (bitmap_reg == '0) && (queued_reg == '0))
        else $error("bitmap or queued flags not cleared by reset");

    a_insert_sets_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ins_ok) |=> ((bitmap_reg & $past(bit_q)) != '0))
        else $error("queue bit not set after insert");

    a_insert_marks_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ins_ok) |=> queued_reg[$past(t_idx)])
        else $error("thread not marked queued after insert");

    a_reject_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !ins_ok && !rem_ok) |=> ($stable(bitmap_reg) && $stable(queued_reg)))
        else $error("rejected transaction changed queue state");

endmodule

FILE: rtl/priority_run_queue_insert_remove_unit.sv
// Top level of the priority run queue insert/remove unit: stream handshake and registers.
// Instantiates prq_queue_core; depends on prq_pkg.
//
// channel | dir | tdata (low bit up)                    | tuser
// s_      | in  | thread_id[5:0], priority_req[12:6]    | command[0]
// m_      | out | status[1:0], nonempty_bitmap[33:2]    | -
//
// One transaction per cycle while m_ is not stalled; the core makes all link updates
// of a transaction in the same cycle. Path: input register, then result register.
// Reset (aresetn low, synchronous) empties every queue and drops held transactions.
// A stalled result holds m_; s_tready drops only when both registers are full and stalled.
module priority_run_queue_insert_remove_unit
    import prq_pkg::*;
#(
    parameter int NUM_THREADS = PRQ_NUM_THREADS,
    parameter int NUM_QUEUES  = PRQ_NUM_QUEUES,
    parameter int PRIO_SHIFT  = PRQ_PRIO_SHIFT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // thread_id[5:0], priority_req[12:6], zero pad
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], nonempty_bitmap[33:2], zero pad
);

    prq_op_t  in_op_reg;
    logic     in_valid_reg;
    prq_res_t out_res_reg;
    logic     out_valid_reg;
    prq_res_t core_res;
    logic     out_free;
    logic     fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    prq_queue_core #(
        .NUM_THREADS (NUM_THREADS),
        .NUM_QUEUES  (NUM_QUEUES),
        .PRIO_SHIFT  (PRIO_SHIFT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_tvalid && s_tready),
        .load_tid (s_tdata[5:0]),
        .fire     (fire),
        .op       (in_op_reg),
        .res      (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg.cmd          <= prq_cmd_t'(s_tuser[0]);
            in_op_reg.thread_id    <= s_tdata[5:0];
            in_op_reg.priority_req <= s_tdata[12:6];
        end
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.bitmap, out_res_reg.status};

endmodule

FILE: tb/tb_priority_run_queue_insert_remove_unit.sv
// Self-checking testbench for priority_run_queue_insert_remove_unit.
// Runs a directed table and then random insert/remove traffic under several idle and stall
// mixes, and checks every result against a typed table value or a run queue predictor. Depends on prq_pkg.
module tb_priority_run_queue_insert_remove_unit
    import prq_pkg::*;
;

    typedef logic [6:0] node_t;

    typedef struct packed {
        prq_cmd_t    cmd;
        logic [5:0]  tid;
        logic [6:0]  prio;
        logic        typed;
        prq_status_t st;
        logic [31:0] bm;
    } op_row_t;

    localparam int DIR_ROWS   = 23;
    localparam int RAND_ITEMS = 900;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // predictor state
    node_t       fwd_link  [PRQ_NUM_THREADS];
    node_t       back_link [PRQ_NUM_THREADS];
    logic        on_queue  [PRQ_NUM_THREADS];
    logic [6:0]  thread_prio [PRQ_NUM_THREADS];
    node_t       q_head [PRQ_NUM_QUEUES];
    node_t       q_tail [PRQ_NUM_QUEUES];
    logic [31:0] busy_map;

    prq_res_t    pending_res [$];
    prq_res_t    oldest_res;
    op_row_t     dir_tab [DIR_ROWS];

    int mismatch_count = 0;
    int results_checked = 0;
    int n_inserts = 0;
    int n_removes = 0;
    int n_done = 0;
    int n_dup = 0;
    int n_bad = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;

    priority_run_queue_insert_remove_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic node_t anchor_node(int q);
        return node_t'(PRQ_NUM_THREADS + q);
    endfunction

    function automatic void link_fwd(node_t node, node_t val);
        if (node < PRQ_NUM_THREADS) begin
            fwd_link[node] = val;
        end else if (node < PRQ_NUM_THREADS + PRQ_NUM_QUEUES) begin
            q_head[node - PRQ_NUM_THREADS] = val;
        end
    endfunction

    function automatic void link_back(node_t node, node_t val);
        if (node < PRQ_NUM_THREADS) begin
            back_link[node] = val;
        end else if (node < PRQ_NUM_THREADS + PRQ_NUM_QUEUES) begin
            q_tail[node - PRQ_NUM_THREADS] = val;
        end
    endfunction

    function automatic void clear_run_queues();
        for (int i = 0; i < PRQ_NUM_THREADS; i++) begin
            fwd_link[i] = '0;
            back_link[i] = '0;
            on_queue[i] = 1'b0;
            thread_prio[i] = '0;
        end
        for (int i = 0; i < PRQ_NUM_QUEUES; i++) begin
            q_head[i] = anchor_node(i);
            q_tail[i] = anchor_node(i);
        end
        busy_map = '0;
    endfunction

    // Applies one insert/remove to the run queues and returns the status and bitmap.
    function automatic prq_res_t update_run_queues(prq_cmd_t cmd, logic [5:0] tid,
                                                   logic [6:0] prio);
        int       t;
        int       q;
        node_t    last;
        node_t    nx;
        node_t    pv;
        prq_res_t res;
        t = int'(tid) % PRQ_NUM_THREADS;
        q = int'(prio) >> PRQ_PRIO_SHIFT;
        if (q >= PRQ_NUM_QUEUES) begin
            q = PRQ_NUM_QUEUES - 1;
        end
        res.status = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (on_queue[t]) begin
                res.status = ST_DUP_INSERT;
            end else begin
                last = q_tail[q];
                busy_map[q] = 1'b1;
                fwd_link[t] = anchor_node(q);
                back_link[t] = last;
                q_tail[q] = node_t'(t);
                link_fwd(last, node_t'(t));
                on_queue[t] = 1'b1;
                thread_prio[t] = prio;
            end
        end else begin
            if (!on_queue[t] || !busy_map[q]) begin
                res.status = ST_BAD_REMOVE;
            end else begin
                nx = fwd_link[t];
                pv = back_link[t];
                link_back(nx, pv);
                link_fwd(pv, nx);
                on_queue[t] = 1'b0;
                if (q_head[q] == anchor_node(q)) begin
                    busy_map[q] = 1'b0;
                end
            end
        end
        res.bitmap = busy_map;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drives one transaction and records its expected result once accepted.
    task automatic send_op(prq_cmd_t cmd, logic [5:0] tid, logic [6:0] prio, logic typed,
                           prq_res_t typed_res);
        prq_res_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            s_tdata = 16'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {3'b000, prio, tid};
        s_tuser = cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = update_run_queues(cmd, tid, prio);
        if (cmd == CMD_INSERT) n_inserts++;
        else n_removes++;
        case (res.status)
            ST_DONE:       n_done++;
            ST_DUP_INSERT: n_dup++;
            default:       n_bad++;
        endcase
        pending_res.push_back(typed ? typed_res : res);
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("result with none pending", m_tdata[33:2], '0);
            end else begin
                oldest_res = pending_res.pop_front();
                results_checked++;
                if (m_tdata[1:0] != oldest_res.status)
                    report_mismatch("status", 32'(m_tdata[1:0]), 32'(oldest_res.status));
                if (m_tdata[33:2] != oldest_res.bitmap)
                    report_mismatch("nonempty_bitmap", m_tdata[33:2], oldest_res.bitmap);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int         pick;
        int         wait_cycles;
        prq_cmd_t   cmd;
        logic [5:0] tid;
        logic [6:0] prio;
        prq_res_t   typed_res;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        clear_run_queues();

        dir_tab = '{
            // remove from empty unit, then duplicate insert, extremes of slot and priority
            '{CMD_REMOVE, 6'd0,  7'd0,   1'b1, ST_BAD_REMOVE, 32'h0000_0000},
            '{CMD_INSERT, 6'd0,  7'd0,   1'b1, ST_DONE,       32'h0000_0001},
            '{CMD_INSERT, 6'd0,  7'd127, 1'b1, ST_DUP_INSERT, 32'h0000_0001},
            '{CMD_INSERT, 6'd63, 7'd127, 1'b1, ST_DONE,       32'h8000_0001},
            '{CMD_INSERT, 6'd1,  7'd3,   1'b1, ST_DONE,       32'h8000_0001},
            '{CMD_REMOVE, 6'd1,  7'd0,   1'b1, ST_DONE,       32'h8000_0001},
            // remove naming another queue: unlinked, queue 0 bit left set
            '{CMD_REMOVE, 6'd0,  7'd124, 1'b1, ST_DONE,       32'h8000_0001},
            '{CMD_INSERT, 6'd5,  7'd64,  1'b1, ST_DONE,       32'h8001_0001},
            '{CMD_REMOVE, 6'd63, 7'd127, 1'b1, ST_DONE,       32'h0001_0001},
            // queue bit clear
            '{CMD_REMOVE, 6'd5,  7'd4,   1'b1, ST_BAD_REMOVE, 32'h0001_0001},
            '{CMD_REMOVE, 6'd5,  7'd0,   1'b1, ST_DONE,       32'h0001_0000},
            '{CMD_INSERT, 6'd10, 7'd66,  1'b1, ST_DONE,       32'h0001_0000},
            '{CMD_REMOVE, 6'd10, 7'd65,  1'b1, ST_DONE,       32'h0000_0000},
            // head, middle and tail removal
            '{CMD_INSERT, 6'd2,  7'd32,  1'b0, ST_DONE,       32'h0},
            '{CMD_INSERT, 6'd3,  7'd33,  1'b0, ST_DONE,       32'h0},
            '{CMD_INSERT, 6'd4,  7'd34,  1'b0, ST_DONE,       32'h0},
            '{CMD_REMOVE, 6'd3,  7'd35,  1'b0, ST_DONE,       32'h0},
            '{CMD_REMOVE, 6'd2,  7'd32,  1'b0, ST_DONE,       32'h0},
            '{CMD_INSERT, 6'd62, 7'd96,  1'b0, ST_DONE,       32'h0},
            '{CMD_REMOVE, 6'd4,  7'd34,  1'b0, ST_DONE,       32'h0},
            '{CMD_REMOVE, 6'd62, 7'd99,  1'b0, ST_DONE,       32'h0},
            '{CMD_REMOVE, 6'd62, 7'd99,  1'b0, ST_DONE,       32'h0},
            '{CMD_INSERT, 6'd42, 7'd85,  1'b0, ST_DONE,       32'h0}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            typed_res.status = dir_tab[i].st;
            typed_res.bitmap = dir_tab[i].bm;
            send_op(dir_tab[i].cmd, dir_tab[i].tid, dir_tab[i].prio, dir_tab[i].typed,
                    typed_res);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            case (i / (RAND_ITEMS / 4))
                0:       begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_gap_pct = 65; sink_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  sink_stall_pct = 65; end
                default: begin send_gap_pct = 27; sink_stall_pct = 27; end
            endcase
            // short bursts with no idling inside every phase
            if ((i % 60) < 8) begin
                send_gap_pct = 0;
                sink_stall_pct = 0;
            end
            pick = $urandom_range(99);
            tid = 6'($urandom_range(63));
            if (pick < 75) begin
                if (!on_queue[tid]) begin
                    cmd = CMD_INSERT;
                    prio = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(15));
                end else begin
                    cmd = CMD_REMOVE;
                    prio = {thread_prio[tid][6:2], 2'($urandom_range(3))};
                end
            end else if (pick < 88) begin
                cmd = CMD_REMOVE;
                prio = thread_prio[$urandom_range(63)];
            end else begin
                cmd = prq_cmd_t'($urandom_range(1));
                prio = 7'($urandom_range(127));
            end
            send_op(cmd, tid, prio, 1'b0, typed_res);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        sink_stall_pct = 0;
        while (pending_res.size() != 0) @(posedge aclk);
        wait_cycles = 8;
        repeat (wait_cycles) @(posedge aclk);

        $display("Sent %0d inserts and %0d removes, %0d results compared",
                 n_inserts, n_removes, results_checked);
        $display("Outcomes: %0d done, %0d duplicate inserts, %0d rejected removes",
                 n_done, n_dup, n_bad);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
